@@ sv/tks_pkg.sv @@
// Shared types and constants for the top-k smallest selector.
// Depends on nothing; used by the controller, datapath and top level.
package tks_pkg;

   localparam int KMax = 16;
   localparam int IdxW = $clog2(KMax);
   localparam int CntW = $clog2(KMax + 1);
   localparam int KeepW = 5;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_PUSH  = 3'd1,
      OP_SIFT  = 3'd2,
      OP_POP   = 3'd3,
      OP_ARRV  = 3'd4
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CntW-1:0]     fill;
      logic [IdxW-1:0]     arrv_idx;
   } cmd_type;

   typedef struct packed {
      logic                busy;
      logic signed [31:0]  top;
      logic signed [31:0]  arrv_data;
   } sts_type;

endpackage

@@ sv/tks_datapath.sv @@
// Datapath: heap memory with sift unit and arrival memory.
// Depends on tks_pkg; driven by tks_ctrl through cmd_type/sts_type.
module tks_datapath
   import tks_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_go,
   input  cmd_type            cmd,
   input  logic signed [31:0] din,
   output sts_type            sts
);

   logic signed [31:0] heap_mem [KMax];
   logic signed [31:0] arrv_mem [KMax];

   typedef enum logic [3:0] {
      D_IDLE = 4'b0001,
      D_UP   = 4'b0010,
      D_DOWN = 4'b0100,
      D_POPL = 4'b1000
   } dst_type;

   dst_type dst_ff, dst_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic [CntW-1:0] n_ff, n_in;
   logic signed [31:0] val_ff, val_in;
   logic signed [31:0] top_ff, top_in;
   logic signed [31:0] arrv_rd_ff;
   logic [CntW:0] lc, rc;
   logic signed [31:0] lv, rv, pv;
   logic [IdxW-1:0] par;
   logic we;
   logic [IdxW-1:0] wa;
   logic signed [31:0] wd;

   always_comb begin
      lc = {pos_ff, 1'b1};
      rc = lc + 1'b1;
      lv = heap_mem[lc[IdxW-1:0]];
      rv = heap_mem[rc[IdxW-1:0]];
      par = IdxW'((pos_ff - 1'b1) >> 1);
      pv = heap_mem[par];
   end

   always_comb begin
      dst_in = dst_ff;
      pos_in = pos_ff;
      n_in = n_ff;
      val_in = val_ff;
      top_in = top_ff;
      we = 1'b0;
      wa = '0;
      wd = val_ff;
      unique case (dst_ff)
         D_IDLE: begin
            if (cmd_go) begin
               case (cmd.op)
                  OP_PUSH: begin
                     val_in = din; pos_in = cmd.fill; n_in = cmd.fill + 1'b1;
                     dst_in = D_UP;
                  end
                  OP_SIFT: begin
                     val_in = din; pos_in = '0; n_in = cmd.fill; dst_in = D_DOWN;
                  end
                  OP_POP: begin
                     n_in = cmd.fill - 1'b1; dst_in = D_POPL;
                  end
                  OP_ARRV: begin
                     we = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         D_POPL: begin
            val_in = heap_mem[n_ff[IdxW-1:0]];
            pos_in = '0;
            dst_in = D_DOWN;
         end
         D_UP: begin
            // climb while parent is smaller
            if (pos_ff != '0 && pv < val_ff) begin
               we = 1'b1; wa = pos_ff[IdxW-1:0]; wd = pv;
               pos_in = CntW'(par);
            end else begin
               we = 1'b1; wa = pos_ff[IdxW-1:0]; wd = val_ff;
               dst_in = D_IDLE;
            end
         end
         D_DOWN: begin
            if (lc < (CntW+1)'(n_ff) && lv > val_ff &&
                !(rc < (CntW+1)'(n_ff) && rv > lv)) begin
               we = 1'b1; wa = pos_ff[IdxW-1:0]; wd = lv;
               pos_in = lc[CntW-1:0];
            end else if (rc < (CntW+1)'(n_ff) && rv > val_ff) begin
               we = 1'b1; wa = pos_ff[IdxW-1:0]; wd = rv;
               pos_in = rc[CntW-1:0];
            end else begin
               we = 1'b1; wa = pos_ff[IdxW-1:0]; wd = val_ff;
               dst_in = D_IDLE;
            end
         end
         default: dst_in = D_IDLE;
      endcase
      if (we && wa == '0) top_in = wd;
   end

   always_ff @(posedge clock) begin
      if (we) heap_mem[wa] <= wd;
      if (cmd_go && dst_ff == D_IDLE && cmd.op == OP_ARRV) arrv_mem[cmd.arrv_idx] <= din;
      if (cmd_go && dst_ff == D_IDLE && cmd.op == OP_PUSH) arrv_mem[cmd.arrv_idx] <= din;
      arrv_rd_ff <= arrv_mem[cmd.arrv_idx];
      val_ff <= val_in;
      top_ff <= top_in;
      pos_ff <= pos_in;
      n_ff <= n_in;
      if (reset) dst_ff <= D_IDLE;
      else dst_ff <= dst_in;
   end

   assign sts = '{busy: (dst_ff != D_IDLE), top: top_ff, arrv_data: arrv_rd_ff};

   a_popl_down: assert property (@(posedge clock) disable iff (reset)
      dst_ff == D_POPL |=> dst_ff == D_DOWN) else $error("pop must sift");
   a_go_idle: assert property (@(posedge clock) disable iff (reset)
      dst_ff == D_UP && dst_in == D_IDLE |-> we) else $error("final write missing");
   a_down_bound: assert property (@(posedge clock) disable iff (reset)
      dst_ff == D_DOWN |-> pos_ff < n_ff || n_ff == '0) else $error("sift out of range");

endmodule

@@ sv/tks_ctrl.sv @@
// Controller: run bookkeeping, handshakes and output register.
// Depends on tks_pkg; commands tks_datapath.
module tks_ctrl
   import tks_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [KeepW-1:0]   keep,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic signed [31:0] in_val,
   input  logic               in_last,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [31:0] out_val,
   output logic               out_last,
   output logic               cmd_go,
   output cmd_type            cmd,
   input  sts_type            sts
);

   typedef enum logic [4:0] {
      S_IN   = 5'b00001,
      S_WAIT = 5'b00010,
      S_POP  = 5'b00100,
      S_ARD  = 5'b01000,
      S_OUT  = 5'b10000
   } st_type;

   st_type st_ff, st_in;
   logic [CntW-1:0] seen_ff, seen_in, fill_ff, fill_in, run_ff, run_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic last_ff, last_in;
   logic ov_ff, ov_in, ol_ff, ol_in;
   logic signed [31:0] od_ff, od_in;
   logic [CntW-1:0] rk;
   logic acc;

   always_comb begin
      rk = (seen_ff == '0 && fill_ff == '0) ?
           ((keep > KeepW'(KMax)) ? CntW'(KMax) : CntW'(keep)) : run_ff;
      st_in = st_ff; seen_in = seen_ff; fill_in = fill_ff; run_in = run_ff;
      idx_in = idx_ff; last_in = last_ff;
      ov_in = ov_ff; ol_in = ol_ff; od_in = od_ff;
      cmd_go = 1'b0; cmd = '{op: OP_NONE, fill: fill_ff, arrv_idx: idx_ff[IdxW-1:0]};
      in_ready = (st_ff == S_IN) && !ov_ff;
      acc = in_valid && in_ready;
      if (ov_ff && out_ready) ov_in = 1'b0;
      unique case (st_ff)
         S_IN: if (acc) begin
            run_in = rk; last_in = in_last;
            if (rk != '0 && seen_ff < rk) begin
               cmd_go = 1'b1;
               cmd = '{op: OP_PUSH, fill: fill_ff, arrv_idx: seen_ff[IdxW-1:0]};
               seen_in = seen_ff + 1'b1; fill_in = fill_ff + 1'b1;
               st_in = S_WAIT;
            end else if (rk != '0 && fill_ff != '0 && in_val < sts.top) begin
               cmd_go = 1'b1;
               cmd = '{op: OP_SIFT, fill: fill_ff, arrv_idx: '0};
               st_in = S_WAIT;
            end else if (in_last) begin
               // full heap left untouched by the last item: drain it
               if (rk != '0) st_in = S_WAIT;
               else begin
                  seen_in = '0; fill_in = '0;
               end
            end
         end
         S_WAIT: if (!sts.busy) begin
            if (!last_ff) st_in = S_IN;
            else if (seen_ff < run_ff) begin
               idx_in = '0; st_in = S_ARD;
            end else begin
               st_in = S_POP;
            end
         end
         S_POP: if (!sts.busy && !ov_ff) begin
            // capture top, then pop and sift
            od_in = sts.top; ov_in = 1'b1; ol_in = (fill_ff == CntW'(1));
            fill_in = fill_ff - 1'b1;
            if (fill_ff != CntW'(1)) begin
               cmd_go = 1'b1; cmd = '{op: OP_POP, fill: fill_ff, arrv_idx: '0};
            end else begin
               seen_in = '0; st_in = S_IN;
            end
         end
         S_ARD: st_in = S_OUT;
         S_OUT: if (!ov_ff) begin
            od_in = sts.arrv_data; ov_in = 1'b1;
            ol_in = (idx_ff + 1'b1 == seen_ff);
            idx_in = idx_ff + 1'b1;
            cmd = '{op: OP_NONE, fill: fill_ff, arrv_idx: IdxW'(idx_ff + 1'b1)};
            if (ol_in) begin
               seen_in = '0; fill_in = '0; st_in = S_IN;
            end else st_in = S_ARD;
         end
         default: st_in = S_IN;
      endcase
      if (st_ff == S_ARD) cmd.arrv_idx = idx_ff[IdxW-1:0];
   end

   always_ff @(posedge clock) begin
      od_ff <= od_in; ol_ff <= ol_in; run_ff <= run_in; idx_ff <= idx_in;
      last_ff <= last_in;
      if (reset) begin
         st_ff <= S_IN; seen_ff <= '0; fill_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; seen_ff <= seen_in; fill_ff <= fill_in; ov_ff <= ov_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_val = od_ff;
   assign out_last = ol_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CntW'(KMax)) else $error("heap overfilled");
   a_seen_fill: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= seen_ff) else $error("fill exceeds seen");
   a_no_in_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != S_IN |-> !in_ready) else $error("ready while busy");

endmodule

@@ sv/top_k_smallest_selector.sv @@
// Top-k smallest selector: keeps the k smallest signed values of a stream.
// A push or replace stalls the input while the heap sifts, one heap level per cycle.
// A full heap drains by capturing the top, then popping and sifting, for each result.
// Drain of a short stream: results are read from the arrival memory.
// Reset (synchronous, active high): keep_count returns to 1, run state clears.
// Depends on tks_pkg, tks_ctrl and tks_datapath.
module top_k_smallest_selector
   import tks_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample_value
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] kept_value
   output logic        rsp_tlast    // is_final
);

   logic [KeepW-1:0] keep_ff;
   logic cmd_go;
   cmd_type cmd;
   sts_type sts;
   logic signed [31:0] ov;

   // hold keep count; latched per run in the controller
   always_ff @(posedge clock) begin
      if (reset) keep_ff <= KeepW'(1);
      else if (csr_we) keep_ff <= csr_wdata;
   end

   tks_ctrl u_ctrl (
      .clock, .reset, .keep(keep_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_val(signed'(req_tdata)), .in_last(req_tlast),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_val(ov), .out_last(rsp_tlast),
      .cmd_go, .cmd, .sts
   );

   tks_datapath u_dp (
      .clock, .reset, .cmd_go, .cmd, .din(signed'(req_tdata)), .sts
   );

   assign rsp_tdata = ov;

endmodule
